// ===== rtl/bfg_pkg.sv =====
// Package for the byte ring FIFO with burst reads: sizes, item kind codes
// and the command/status structs shared by controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package bfg_pkg;

   localparam int DEPTH     = 1024;
   localparam int MAX_BURST = 64;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PTR_W  = ADDR_W + 1;
   localparam int CNT_W  = 7;
   localparam int CMP_W  = (PTR_W > CNT_W) ? PTR_W : CNT_W;
   localparam int BYTE_W = 8;
   localparam int KIND_W = 2;
   localparam int LVL_W  = 11;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;

   localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GET   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAN = 2'd2;

   typedef struct packed {
      logic do_put;
      logic do_clean;
      logic do_status;
      logic do_get_start;
      logic do_load_byte;
      logic do_read_next;
   } cmd_type;

   typedef struct packed {
      logic out_valid;
      logic get_empty;
      logic rem_zero;
   } status_type;

endpackage

// ===== rtl/bfg_ctrl.sv =====
// Controller for the byte ring FIFO: decodes request kinds and sequences
// get bursts. Depends on bfg_pkg.
`timescale 1ns / 1ps

module bfg_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic [bfg_pkg::KIND_W-1:0] req_kind,
   input  logic                      rsp_tready,
   input  bfg_pkg::status_type       status,
   output logic                      req_tready,
   output bfg_pkg::cmd_type          cmd
);
   import bfg_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_LOAD = 1'b1;

   logic state_ff;
   logic state_in;
   logic out_free;
   logic accept;

   assign out_free = !status.out_valid || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  KIND_PUT: begin
                     cmd.do_put = 1'b1;
                  end
                  KIND_GET: begin
                     if (status.get_empty) begin
                        cmd.do_status = 1'b1;
                     end else begin
                        cmd.do_get_start = 1'b1;
                        state_in         = S_LOAD;
                     end
                  end
                  KIND_CLEAN: begin
                     cmd.do_clean = 1'b1;
                  end
                  default: begin
                     cmd.do_status = 1'b1;
                  end
               endcase
            end
         end
         S_LOAD: begin
            if (out_free) begin
               cmd.do_load_byte = 1'b1;
               if (status.rem_zero) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.do_read_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/bfg_datapath.sv =====
// Datapath for the byte ring FIFO: ring memory, pointers, lost flag,
// burst counter and the result register. Depends on bfg_pkg.
`timescale 1ns / 1ps

module bfg_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  bfg_pkg::cmd_type           cmd,
   input  logic [bfg_pkg::BYTE_W-1:0] put_byte,
   input  logic [bfg_pkg::CNT_W-1:0]  request_count,
   input  logic                       rsp_tready,
   output bfg_pkg::status_type        status,
   output logic                       rsp_tvalid,
   output logic [bfg_pkg::BYTE_W-1:0] out_byte,
   output logic                       byte_valid,
   output logic                       is_last,
   output logic                       put_accepted,
   output logic [bfg_pkg::LVL_W-1:0]  fill_level,
   output logic                       lost_seen
);
   import bfg_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             lost_ff, lost_in;
   logic [CNT_W-1:0] rem_ff, rem_in;

   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              bvalid_ff, bvalid_in;
   logic              last_ff, last_in;
   logic              acc_ff, acc_in;
   logic [PTR_W-1:0]  level_ff, level_in;
   logic              lost_out_ff, lost_out_in;

   logic [PTR_W-1:0] level;
   logic             put_ok;
   logic             mem_we;
   logic             rd_en;
   logic [CNT_W-1:0] cnt_sat;
   logic [CNT_W-1:0] burst_n;
   logic             load;

   assign level  = wr_ptr_ff - rd_ptr_ff;
   assign put_ok = (level != PTR_W'(DEPTH));
   assign mem_we = cmd.do_put && put_ok;
   assign rd_en  = cmd.do_get_start || cmd.do_read_next;

   // Clamp the request to the burst limit, then to what is held.
   assign cnt_sat = (request_count > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : request_count;
   assign burst_n = (CMP_W'(level) < CMP_W'(cnt_sat)) ? CNT_W'(level) : cnt_sat;

   assign status.out_valid = out_valid_ff;
   assign status.get_empty = (burst_n == '0);
   assign status.rem_zero  = (rem_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      rem_in    = rem_ff;
      lost_in   = lost_ff | (cmd.do_put & ~put_ok);
      if (cmd.do_clean) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
      end else begin
         if (mem_we) begin
            wr_ptr_in = wr_ptr_ff + PTR_W'(1);
         end
         if (rd_en) begin
            rd_ptr_in = rd_ptr_ff + PTR_W'(1);
         end
      end
      if (cmd.do_get_start) begin
         rem_in = burst_n - CNT_W'(1);
      end else if (cmd.do_read_next) begin
         rem_in = rem_ff - CNT_W'(1);
      end
   end

   // Result register: one entry, loaded by any result-producing command.
   assign load = cmd.do_put || cmd.do_clean || cmd.do_status || cmd.do_load_byte;

   always_comb begin
      out_byte_in = '0;
      bvalid_in   = 1'b0;
      last_in     = 1'b1;
      acc_in      = 1'b0;
      level_in    = level;
      lost_out_in = lost_ff;
      if (cmd.do_put) begin
         acc_in      = put_ok;
         level_in    = level + PTR_W'(put_ok);
         lost_out_in = lost_in;
      end else if (cmd.do_clean) begin
         level_in = '0;
      end else if (cmd.do_load_byte) begin
         out_byte_in = rd_data_ff;
         bvalid_in   = 1'b1;
         last_in     = (rem_ff == '0);
      end
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ptr_ff[ADDR_W-1:0]] <= put_byte;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_ptr_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         lost_ff      <= 1'b0;
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         lost_ff      <= lost_in;
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= out_byte_in;
         bvalid_ff   <= bvalid_in;
         last_ff     <= last_in;
         acc_ff      <= acc_in;
         level_ff    <= level_in;
         lost_out_ff <= lost_out_in;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign out_byte     = out_byte_ff;
   assign byte_valid   = bvalid_ff;
   assign is_last      = last_ff;
   assign put_accepted = acc_ff;
   assign fill_level   = LVL_W'(level_ff);
   assign lost_seen    = lost_out_ff;

endmodule

// ===== rtl/byte_ring_fifo_burst_get.sv =====
// Top level of the byte ring FIFO with burst reads.
// Depends on bfg_pkg, bfg_ctrl and bfg_datapath.
`timescale 1ns / 1ps

// Usage:
//   The req_ channel carries one request per handshake. req_tuser is the
//   kind: put a byte, get a burst, or clean. A put stores req_tdata[7:0]
//   when there is room, else drops it and sets the sticky lost flag. A get
//   returns min(count, 64, level) bytes oldest first; a get that finds
//   nothing returns one status result. A clean empties the FIFO and keeps
//   the lost flag. The rsp_ channel carries every result with its level
//   and the lost flag; rsp_tlast marks the final result of a request.
// Throughput:
//   A put, clean or status result is registered and shows in the cycle
//   after the request is taken; a new request can be taken every cycle
//   while rsp_tready is high and no get is in progress. A get reads its
//   first byte into the read data register, then the result register,
//   then one byte per cycle while rsp_tready is high, paced by the ring's
//   single read port; the next request is taken back in the idle state.
// Reset and stall:
//   Reset empties the FIFO and clears the lost flag; ring contents are left
//   as they are. While a result waits and rsp_tready is low, the result
//   register holds, no new request is taken, and a burst pauses without loss.
module byte_ring_fifo_burst_get (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] put_byte, [14:8] request_count, [15] zero
   input  logic [bfg_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] kind
   input  logic [bfg_pkg::KIND_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] out_byte, [8] put_accepted, [19:9] fill_level, [20] lost_seen,
   // [23:21] zero
   output logic [bfg_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [0] byte_valid
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);
   import bfg_pkg::*;

   cmd_type    cmd;
   status_type status;

   logic [BYTE_W-1:0] out_byte;
   logic              put_accepted;
   logic [LVL_W-1:0]  fill_level;
   logic              lost_seen;

   // Sequence requests and bursts.
   bfg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .rsp_tready (rsp_tready),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   // Hold the ring, pointers and result register.
   bfg_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .put_byte      (req_tdata[7:0]),
      .request_count (req_tdata[14:8]),
      .rsp_tready    (rsp_tready),
      .status        (status),
      .rsp_tvalid    (rsp_tvalid),
      .out_byte      (out_byte),
      .byte_valid    (rsp_tuser),
      .is_last       (rsp_tlast),
      .put_accepted  (put_accepted),
      .fill_level    (fill_level),
      .lost_seen     (lost_seen)
   );

   // Pack the result fields, lowest first, pad to whole bytes.
   assign rsp_tdata = {3'b000, lost_seen, fill_level, put_accepted, out_byte};

endmodule
